>>> rtl/core/pfa_pkg.sv
// pfa_pkg: shared types and constants for the page frame allocator
// no dependencies; imported by page_frame_allocator_refcount_top, pfa_checker and tb_top
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int PAGE_W  = 10;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

>>> rtl/core/page_frame_allocator_refcount_top.sv
// page_frame_allocator_refcount_top: lifo free list of page frames with 16-bit reference counts
// depends on pfa_pkg for op and status codes and field types
`timescale 1ns / 1ps

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+----------------------------------
// command  | in        | start high, busy low  | i_op, i_page
// result   | out       | o_valid, one cycle    | o_page_out, o_ref_count, o_status
//
// one transaction can be accepted every cycle while busy is low; the result strobe
// comes from the result register, which follows the execute stage
// the count memory is read at the accepting edge and written from the execute stage at the following edge;
// a write that hits the next transaction's address is forwarded, same for the stack
// after reset the count memory is cleared one entry per cycle, over all min(NUM_PAGES, 1024)
// entries, with busy high; no transaction is accepted during that pass
// the receiver cannot stall, so busy is high only during the clearing pass

module page_frame_allocator_refcount_top #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [pfa_pkg::OP_W-1:0]   i_op,
    input  pfa_pkg::t_page             i_page,
    output logic                       o_valid,
    output pfa_pkg::t_page             o_page_out,
    output pfa_pkg::t_count            o_ref_count,
    output logic [pfa_pkg::STAT_W-1:0] o_status
);
    import pfa_pkg::*;

    // count memory covers only pages a 10-bit index can reach
    localparam int CNT_DEPTH = (NUM_PAGES < (1 << PAGE_W)) ? NUM_PAGES : (1 << PAGE_W);
    localparam int IDX_W     = $clog2(CNT_DEPTH);
    localparam int SA_W      = $clog2(NUM_PAGES);
    localparam int FC_W      = $clog2(NUM_PAGES + 1);

    localparam logic [IDX_W-1:0] CLR_LAST   = IDX_W'(CNT_DEPTH - 1);
    localparam logic [FC_W-1:0]  FC_FULL    = FC_W'(NUM_PAGES);
    localparam logic [16:0]      PAGE_LIMIT = 17'(NUM_PAGES);

    // storage
    t_count              r_cnt_mem [CNT_DEPTH];
    t_page               r_stk_mem [NUM_PAGES];
    logic [FC_W-1:0]     r_free_count;

    // clearing pass
    logic                r_clearing;
    logic [IDX_W-1:0]    r_clr_addr;

    // execute stage
    logic                r_s_v;
    logic [OP_W-1:0]     r_s_op;
    t_page               r_s_page;
    t_count              r_cnt_mem_q;
    logic                r_cnt_fwd;
    t_count              r_cnt_fwd_q;
    t_page               r_stk_mem_q;
    logic                r_stk_fwd;
    t_page               r_stk_fwd_q;

    // result register
    logic                r_o_valid;
    t_page               r_o_page;
    t_count              r_o_cnt;
    logic [STAT_W-1:0]   r_o_status;

    // execute stage next values
    logic [FC_W-1:0]     n_free_count;
    logic                n_cw_en;
    logic [IDX_W-1:0]    n_cw_addr;
    t_count              n_cw_data;
    logic                n_push_en;
    t_page               n_res_page;
    t_count              n_res_cnt;
    logic [STAT_W-1:0]   n_res_status;

    logic                accept;
    t_count              s_cnt;
    t_page               s_top;
    logic                s_page_ok;
    logic                s_full;
    t_count              s_dec;
    logic [FC_W-1:0]     fc_minus1;
    logic [SA_W-1:0]     stk_raddr;
    logic [SA_W-1:0]     stk_waddr;
    logic [IDX_W-1:0]    cnt_raddr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_count              mem_wdata;

    assign busy     = r_clearing;
    assign accept   = start && !r_clearing;

    // operands as seen by the execute stage, with forwarding applied
    assign s_cnt     = r_cnt_fwd ? r_cnt_fwd_q : r_cnt_mem_q;
    assign s_top     = r_stk_fwd ? r_stk_fwd_q : r_stk_mem_q;
    assign s_page_ok = ({7'b0, r_s_page} < PAGE_LIMIT);
    assign s_full    = (r_free_count >= FC_FULL);
    assign s_dec     = (s_cnt != '0) ? (s_cnt - 16'd1) : '0;

    // execute: one read-modify-write of the count and the stack pointer
    always_comb begin
        n_free_count = r_free_count;
        n_cw_en      = 1'b0;
        n_cw_addr    = r_s_page[IDX_W-1:0];
        n_cw_data    = '0;
        n_push_en    = 1'b0;
        n_res_page   = r_s_page;
        n_res_cnt    = '0;
        n_res_status = ST_OK;
        if (r_s_v) begin
            if (r_s_op == OP_ALLOC) begin
                if (r_free_count == '0) begin
                    n_res_page   = '0;
                    n_res_status = ST_EMPTY;
                end else begin
                    // stack only ever holds in-range pages
                    n_free_count = r_free_count - FC_W'(1);
                    n_res_page   = s_top;
                    n_res_cnt    = 16'd1;
                    n_cw_en      = 1'b1;
                    n_cw_addr    = s_top[IDX_W-1:0];
                    n_cw_data    = 16'd1;
                end
            end else if (s_page_ok) begin
                case (r_s_op)
                    OP_FREE: begin
                        n_cw_en   = 1'b1;
                        n_cw_data = '0;
                        n_res_cnt = '0;
                        n_push_en = 1'b1;
                    end
                    OP_INC: begin
                        n_cw_en   = 1'b1;
                        n_cw_data = s_cnt + 16'd1;
                        n_res_cnt = s_cnt + 16'd1;
                    end
                    OP_DEC: begin
                        n_cw_en   = 1'b1;
                        n_cw_data = s_dec;
                        n_res_cnt = s_dec;
                        // reaching zero, or already zero, frees the page again
                        n_push_en = (s_dec == '0);
                    end
                    default: begin
                        // read and unused codes report the count untouched
                        n_res_cnt = s_cnt;
                    end
                endcase
                if (n_push_en) begin
                    if (s_full) begin
                        n_push_en    = 1'b0;
                        n_res_status = ST_FULL;
                    end else begin
                        n_free_count = r_free_count + FC_W'(1);
                    end
                end
            end
        end
    end

    // stack addresses: read the top that the next transaction will see
    assign fc_minus1 = n_free_count - FC_W'(1);
    assign stk_raddr = fc_minus1[SA_W-1:0];
    assign stk_waddr = r_free_count[SA_W-1:0];
    assign cnt_raddr = i_page[IDX_W-1:0];

    // count memory write port shared with the clearing pass
    assign mem_we    = r_clearing || n_cw_en;
    assign mem_waddr = r_clearing ? r_clr_addr : n_cw_addr;
    assign mem_wdata = r_clearing ? '0 : n_cw_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cnt_mem[mem_waddr] <= mem_wdata;
        end
        r_cnt_mem_q <= r_cnt_mem[cnt_raddr];
        r_cnt_fwd   <= n_cw_en && (n_cw_addr == cnt_raddr);
        r_cnt_fwd_q <= n_cw_data;
    end

    always_ff @(posedge i_clk) begin
        if (n_push_en) begin
            r_stk_mem[stk_waddr] <= r_s_page;
        end
        r_stk_mem_q <= r_stk_mem[stk_raddr];
        r_stk_fwd   <= n_push_en && (stk_waddr == stk_raddr);
        r_stk_fwd_q <= r_s_page;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_free_count <= '0;
            r_s_v        <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            r_free_count <= n_free_count;
            r_s_v        <= accept;
            r_o_valid    <= r_s_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_op   <= i_op;
            r_s_page <= i_page;
        end
        r_o_page   <= n_res_page;
        r_o_cnt    <= n_res_cnt;
        r_o_status <= n_res_status;
    end

    assign o_valid     = r_o_valid;
    assign o_page_out  = r_o_page;
    assign o_ref_count = r_o_cnt;
    assign o_status    = r_o_status;

    // the clearing pass never overlaps a transaction in flight
    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s_v)
        else $error("transaction in execute stage during clearing pass");

    // every executed transaction yields exactly one result strobe
    a_result_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |=> o_valid)
        else $error("executed transaction produced no result");

    // free count stays within the pool
    a_free_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= FC_FULL)
        else $error("free count above pool size");

    // free count changes only when a transaction executes
    a_free_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s_v |=> $stable(r_free_count))
        else $error("free count changed with no transaction");

    // an empty allocate reports page zero and count zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_page_out == '0 && o_ref_count == '0))
        else $error("empty allocate returned nonzero fields");

endmodule

>>> dv/pfa_checker.sv
// pfa_checker: watches the command and result channels of the page frame allocator
// keeps its own free list and count table, predicts each result and compares it; uses pfa_pkg
`timescale 1ns / 1ps

module pfa_checker #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [pfa_pkg::OP_W-1:0]   i_op,
    input  pfa_pkg::t_page             i_page,
    input  logic                       i_valid,
    input  pfa_pkg::t_page             i_page_out,
    input  pfa_pkg::t_count            i_ref_count,
    input  logic [pfa_pkg::STAT_W-1:0] i_status,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    import pfa_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        t_page   frame;
        t_count  refs;
        t_status status;
    } t_frame_result;

    t_page         free_frames [NUM_PAGES];
    int            free_depth;
    t_count        frame_refcnt [NUM_PAGES];
    t_frame_result frame_results_due[$];
    int            mismatch_count;
    int            cmds_taken;
    int            results_seen;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = cmds_taken - results_seen;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // clear the count and push the frame unless the list is full
    function automatic t_status release_frame(input t_page pg);
        frame_refcnt[pg] = '0;
        if (free_depth >= NUM_PAGES)
            return ST_FULL;
        free_frames[free_depth] = pg;
        free_depth++;
        return ST_OK;
    endfunction

    function automatic t_frame_result apply_page_op(input logic [OP_W-1:0] op, input t_page pg);
        t_frame_result r;
        r.frame  = pg;
        r.refs   = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (free_depth == 0) begin
                r.frame  = '0;
                r.status = ST_EMPTY;
            end else begin
                free_depth--;
                r.frame = free_frames[free_depth];
                if (r.frame < NUM_PAGES) begin
                    frame_refcnt[r.frame] = 1;
                    r.refs = 1;
                end
            end
        end else if (pg < NUM_PAGES) begin
            case (op)
                OP_FREE: r.status = release_frame(pg);
                OP_INC:  frame_refcnt[pg] = frame_refcnt[pg] + 1'b1;
                OP_DEC: begin
                    if (frame_refcnt[pg] != 0)
                        frame_refcnt[pg] = frame_refcnt[pg] - 1'b1;
                    if (frame_refcnt[pg] == 0)
                        r.status = release_frame(pg);
                end
                default: ;
            endcase
            r.refs = frame_refcnt[pg];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result exp_r;
        if (!i_rst_n) begin
            free_depth = 0;
            foreach (frame_refcnt[k])
                frame_refcnt[k] = '0;
            frame_results_due.delete();
            mismatch_count = 0;
            cmds_taken   <= 0;
            results_seen <= 0;
        end else begin
            if (i_valid === 1'b1) begin
                results_seen <= results_seen + 1;
                if (frame_results_due.size() == 0) begin
                    report_mismatch($sformatf("result with no command outstanding, page_out %0d",
                                              i_page_out));
                end else begin
                    exp_r = frame_results_due.pop_front();
                    if (i_page_out !== exp_r.frame)
                        report_mismatch($sformatf("page_out %0d, expected %0d",
                                                  i_page_out, exp_r.frame));
                    if (i_ref_count !== exp_r.refs)
                        report_mismatch($sformatf("ref_count %0d, expected %0d (page %0d)",
                                                  i_ref_count, exp_r.refs, exp_r.frame));
                    if (i_status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %0d (page %0d)",
                                                  i_status, exp_r.status, exp_r.frame));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                cmds_taken <= cmds_taken + 1;
                frame_results_due.push_back(apply_page_op(i_op, i_page));
            end
        end
    end

endmodule

>>> dv/tb_top.sv
// tb_top: stimulus and verdict for page_frame_allocator_refcount_top
// depends on pfa_pkg, the block itself and pfa_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int NUM_PAGES   = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MIX_ITEMS   = 480;
    localparam int CHUNK       = 60;
    localparam int FILL_ITEMS  = 200;
    // op codes the block has no meaning for; they must leave state untouched
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam t_page LAST_PAGE = t_page'(NUM_PAGES - 1);

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_op;
    t_page             i_page;
    logic              o_valid;
    t_page             o_page_out;
    t_count            o_ref_count;
    logic [STAT_W-1:0] o_status;

    int fail_count;
    int outstanding;
    int cycles = 0;

    page_frame_allocator_refcount_top #(
        .NUM_PAGES(NUM_PAGES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_page     (i_page),
        .o_valid    (o_valid),
        .o_page_out (o_page_out),
        .o_ref_count(o_ref_count),
        .o_status   (o_status)
    );

    pfa_checker #(
        .NUM_PAGES(NUM_PAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_valid      (o_valid),
        .i_page_out   (o_page_out),
        .i_ref_count  (o_ref_count),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog: a correct run finishes well within this limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // one command transaction; idle_pct is the chance, per cycle, of holding start low first
    // the transaction is taken at the first edge that sees start high and busy low,
    // which also covers the count clearing pass after reset
    task automatic issue_cmd(input logic [OP_W-1:0] op, input t_page pg, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            // junk on the payload while start is low must be ignored
            i_op   <= OP_W'($urandom);
            i_page <= t_page'($urandom);
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_op   <= op;
        i_page <= pg;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // hold off the sender until every predicted result has been seen
    task automatic wait_results_drained();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
    endtask

    // most traffic lands on a small group of frames so that allocs, frees and
    // count updates keep running into each other; edges and the full range now and then
    function automatic t_page pick_page();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return t_page'($urandom_range(15));
        else if (roll < 70)
            return '0;
        else if (roll < 80)
            return LAST_PAGE;
        else
            return t_page'($urandom_range(NUM_PAGES - 1));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)      return OP_ALLOC;
        else if (roll < 42) return OP_FREE;
        else if (roll < 65) return OP_INC;
        else if (roll < 85) return OP_DEC;
        else if (roll < 98) return OP_READ;
        else                return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    initial begin
        int idle_pct;
        int idle_levels[4];

        // no idling, sender idle 80 percent, receiver phase (cannot stall, so none),
        // both at 17 percent
        idle_levels = '{0, 80, 0, 17};
        start   <= 1'b0;
        i_op    <= OP_READ;
        i_page  <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, edge pages, frees, counts, spare op codes
        issue_cmd(OP_ALLOC, '0, 0);          // empty list on alloc
        issue_cmd(OP_READ,  '0, 0);
        issue_cmd(OP_DEC,   LAST_PAGE, 0);   // decrement of a zero count frees the page
        issue_cmd(OP_FREE,  '0, 0);
        issue_cmd(OP_INC,   LAST_PAGE, 0);
        issue_cmd(OP_ALLOC, LAST_PAGE, 0);   // page input ignored, pops frame 0
        issue_cmd(OP_ALLOC, '0, 0);          // pops the last page, count forced to 1
        issue_cmd(OP_ALLOC, '0, 0);          // empty again
        issue_cmd(OP_INC,   LAST_PAGE, 0);
        issue_cmd(OP_DEC,   LAST_PAGE, 0);
        issue_cmd(OP_DEC,   LAST_PAGE, 0);   // reaches zero, pushed back
        issue_cmd(OP_READ,  LAST_PAGE, 0);
        issue_cmd(OP_FREE,  '0, 0);          // free with a nonzero count
        issue_cmd(OP_READ,  '0, 0);
        issue_cmd(OP_SPARE_LO, LAST_PAGE, 0);
        issue_cmd(OP_SPARE_LO + 3'd1, '0, 0);
        issue_cmd(OP_SPARE_HI, 10'h2AA, 0);
        issue_cmd(OP_INC,   10'h2AA, 0);
        issue_cmd(OP_INC,   10'h155, 0);
        issue_cmd(OP_ALLOC, '0, 0);
        issue_cmd(OP_ALLOC, '0, 0);
        // back to back on one page: exercises the count forwarding path
        issue_cmd(OP_INC,   10'd5, 0);
        issue_cmd(OP_INC,   10'd5, 0);
        issue_cmd(OP_DEC,   10'd5, 0);
        issue_cmd(OP_READ,  10'd5, 0);
        wait_results_drained();

        // build a deep free list with frees, then push more through decrement;
        // pages just freed have a zero count
        for (int n = 0; n < FILL_ITEMS; n++)
            issue_cmd(OP_FREE, t_page'($urandom_range(NUM_PAGES - 1)), 17);
        for (int n = 0; n < 10; n++)
            issue_cmd(OP_DEC, pick_page(), 17);
        // drain it with allocs until it reports empty a few times
        for (int n = 0; n < FILL_ITEMS + 40; n++)
            issue_cmd(OP_ALLOC, t_page'($urandom), 0);

        // random mix, idling level rotating per chunk
        for (int n = 0; n < MIX_ITEMS; n++) begin
            if (n % CHUNK == 0 && (n / CHUNK) % 5 == 2)
                wait_results_drained();
            idle_pct = idle_levels[(n / CHUNK) % 4];
            issue_cmd(pick_op(), pick_page(), idle_pct);
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
